// ===== sv/assert_macros.svh =====
// Assertion macros shared by the throttle RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== sv/dtb_pkg.sv =====
// Shared types and codes for the dual token bucket throttle.
// No dependencies; used by all modules.
package dtb_pkg;

  localparam int HOUR_W      = 5;
  localparam int COUNT_W     = 16;
  localparam int AMOUNT_W    = 32;
  localparam int LIMIT_REG_W = 20;
  localparam int KIB_SHIFT   = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // Input word modes
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_DOWN_REQ = 2'd1;
  localparam logic [1:0] MODE_UP_REQ   = 2'd2;
  localparam logic [1:0] MODE_REPORT   = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_PASS  = 2'd0;
  localparam logic [1:0] STATUS_GRANT = 2'd1;
  localparam logic [1:0] STATUS_RETRY = 2'd2;
  localparam logic [1:0] STATUS_DONE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DOWN_MAIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UP_MAIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DOWN_ALT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UP_ALT       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_ENABLE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_START    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_END      = 3'd6;

  typedef struct packed {
    logic [1:0]          mode;
    logic [HOUR_W-1:0]   current_hour;
    logic [COUNT_W-1:0]  connection_count;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [AMOUNT_W-1:0] grant_bytes;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_step;
    logic clamp;
    logic commit;
  } dtb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_free;
  } dtb_status_t;

endpackage

// ===== sv/dtb_chan_if.sv =====
// Valid/ready channel carrying one payload word per handshake.
// Payload type comes from dtb_pkg at the point of instantiation.
interface dtb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/dtb_datapath.sv =====
// Datapath: configuration registers, token buckets, bit-serial divider,
// grant clamp and output register. Depends on dtb_pkg.
module dtb_datapath #(
  parameter int LIMIT_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dtb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dtb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  dtb_pkg::in_item_t                   item,
  input  dtb_pkg::dtb_cmd_t                   cmd,
  output dtb_pkg::dtb_status_t                sts,
  output logic                                resp_valid,
  input  logic                                resp_ready,
  output dtb_pkg::out_item_t                  resp_item
);
  import dtb_pkg::*;

  localparam int LIMIT_W = (LIMIT_BITS < LIMIT_REG_W) ? LIMIT_BITS : LIMIT_REG_W;
  localparam int TOKEN_W = LIMIT_BITS + KIB_SHIFT;
  localparam int DIV_W   = LIMIT_W + KIB_SHIFT;
  localparam int CMP_W   = (TOKEN_W > AMOUNT_W) ? TOKEN_W : AMOUNT_W;
  localparam int STEP_W  = $clog2(DIV_W);

  logic [LIMIT_W-1:0]  down_main, up_main, down_alt, up_alt;
  logic                win_enable;
  logic [HOUR_W-1:0]   win_start, win_end;
  logic [TOKEN_W-1:0]  down_tokens, up_tokens;

  logic [1:0]          mode;
  logic [HOUR_W-1:0]   hour;
  logic [COUNT_W-1:0]  count;
  logic [AMOUNT_W-1:0] amount;

  logic [DIV_W-1:0]    quo;
  logic [COUNT_W-1:0]  rem;
  logic [STEP_W-1:0]   step;
  logic [AMOUNT_W-1:0] grant;

  logic                out_valid;
  out_item_t           out_item;

  logic                alt;
  logic [LIMIT_W-1:0]  dlim, ulim, lim;
  logic [TOKEN_W-1:0]  tok;
  logic                is_req, unthrottled;
  logic [COUNT_W:0]    trial;
  logic                trial_ge;
  logic [CMP_W-1:0]    q_ext, amt_ext, tok_ext, g1, g2, down_ext;

  // Alternate window, wrapping past midnight when start > end
  always_comb begin
    alt = 1'b0;
    if (win_enable) begin
      if (win_start < win_end) begin
        alt = (hour >= win_start) && (hour < win_end);
      end else if (win_start > win_end) begin
        alt = (hour >= win_start) || (hour < win_end);
      end
    end
  end

  assign dlim        = alt ? down_alt : down_main;
  assign ulim        = alt ? up_alt : up_main;
  assign lim         = (mode == MODE_UP_REQ) ? ulim : dlim;
  assign tok         = (mode == MODE_UP_REQ) ? up_tokens : down_tokens;
  assign is_req      = (mode == MODE_DOWN_REQ) || (mode == MODE_UP_REQ);
  assign unthrottled = (lim == '0) || (count == '0);

  assign trial    = {rem, quo[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, count};

  assign q_ext    = CMP_W'(quo);
  assign amt_ext  = CMP_W'(amount);
  assign tok_ext  = CMP_W'(tok);
  assign down_ext = CMP_W'(down_tokens);
  assign g1       = (q_ext < amt_ext) ? q_ext : amt_ext;
  assign g2       = (g1 < tok_ext) ? g1 : tok_ext;

  assign sts.needs_div = is_req && !unthrottled && (tok != '0);
  assign sts.div_last  = (step == '0);
  assign sts.out_free  = !out_valid || resp_ready;

  assign resp_valid = out_valid;
  assign resp_item  = out_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      down_main  <= '0;
      up_main    <= '0;
      down_alt   <= '0;
      up_alt     <= '0;
      win_enable <= 1'b0;
      win_start  <= '0;
      win_end    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DOWN_MAIN:  down_main  <= cfg_data[LIMIT_W-1:0];
        REG_UP_MAIN:    up_main    <= cfg_data[LIMIT_W-1:0];
        REG_DOWN_ALT:   down_alt   <= cfg_data[LIMIT_W-1:0];
        REG_UP_ALT:     up_alt     <= cfg_data[LIMIT_W-1:0];
        REG_WIN_ENABLE: win_enable <= cfg_data[0];
        REG_WIN_START:  win_start  <= cfg_data[HOUR_W-1:0];
        REG_WIN_END:    win_end    <= cfg_data[HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured word, divider and clamp
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode   <= item.mode;
      hour   <= item.current_hour;
      count  <= item.connection_count;
      amount <= item.amount;
    end
    if (cmd.div_start) begin
      quo  <= {lim, {KIB_SHIFT{1'b0}}};
      rem  <= '0;
      step <= STEP_W'(DIV_W - 1);
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? COUNT_W'(trial - {1'b0, count}) : trial[COUNT_W-1:0];
      quo  <= {quo[DIV_W-2:0], trial_ge};
      step <= step - 1'b1;
    end
    if (cmd.clamp) begin
      // grant never exceeds amount, so it fits the output field
      grant <= g2[AMOUNT_W-1:0];
    end
  end

  // Buckets and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      down_tokens <= '0;
      up_tokens   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        case (mode)
          MODE_TICK: begin
            if (dlim != '0) begin
              down_tokens <= TOKEN_W'({dlim, {KIB_SHIFT{1'b0}}});
            end
            if (ulim != '0) begin
              up_tokens <= TOKEN_W'({ulim, {KIB_SHIFT{1'b0}}});
            end
            out_item.status      <= STATUS_DONE;
            out_item.grant_bytes <= '0;
          end
          MODE_REPORT: begin
            // saturate at zero
            down_tokens <= (amt_ext >= down_ext) ? '0 : TOKEN_W'(down_ext - amt_ext);
            out_item.status      <= STATUS_DONE;
            out_item.grant_bytes <= '0;
          end
          default: begin
            if (unthrottled) begin
              out_item.status      <= STATUS_PASS;
              out_item.grant_bytes <= amount;
            end else if (tok == '0) begin
              out_item.status      <= STATUS_RETRY;
              out_item.grant_bytes <= '0;
            end else begin
              out_item.status      <= STATUS_GRANT;
              out_item.grant_bytes <= grant;
              if (mode == MODE_UP_REQ) begin
                up_tokens <= TOKEN_W'(tok_ext - CMP_W'(grant));
              end
            end
          end
        endcase
      end else if (resp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/dtb_ctrl.sv =====
// Controller: sequences capture, divide, clamp and commit per input word.
// Depends on dtb_pkg for the command and status structs.
module dtb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  dtb_pkg::dtb_status_t sts,
  output dtb_pkg::dtb_cmd_t    cmd
);
  import dtb_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    DECIDE,
    DIVIDE,
    CLAMP,
    COMMIT
  } state_t;

  state_t state;
  logic   accept;

  assign accept = req_valid && req_ready;

  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.div_start = (state == DECIDE) && sts.needs_div;
    cmd.div_step  = (state == DIVIDE);
    cmd.clamp     = (state == CLAMP);
    cmd.commit    = (state == COMMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_ready <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            state     <= DECIDE;
            req_ready <= 1'b0;
          end else begin
            req_ready <= 1'b1;
          end
        end
        DECIDE: begin
          state <= sts.needs_div ? DIVIDE : COMMIT;
        end
        DIVIDE: begin
          if (sts.div_last) begin
            state <= CLAMP;
          end
        end
        CLAMP: begin
          state <= COMMIT;
        end
        COMMIT: begin
          // hold until the output register can take the result
          if (sts.out_free) begin
            state     <= IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= IDLE;
          req_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/dual_token_bucket_bandwidth_throttle.sv =====
// Dual token bucket bandwidth throttle, download and upload.
// Channels: req (sink) takes one word per handshake: a second tick, a
// download or upload request, or a download bytes report. resp (source)
// returns exactly one word per request word: status and grant_bytes.
// Configuration: cfg_write/cfg_index/cfg_data, to be written only while
// idle by the user; the block itself does not enforce this.
// Sequencing: ticks, reports, unthrottled requests and empty-bucket
// retries go from capture straight to commit. A throttled request with
// tokens runs the bit-serial divide of limit*1024 by the connection count,
// one quotient bit per cycle over LIMIT_W+10 bits (30 by default), then
// the clamp, then commit. Flow: one word at a time; req.ready rises at
// the edge that loads the result.
// Reset clears the configuration registers, both buckets, out_valid and
// the controller state; ready rises once reset is released. A stalled
// receiver holds the result in the output register; the next word is
// accepted meanwhile and its own result waits until the register frees.
`include "assert_macros.svh"

module dual_token_bucket_bandwidth_throttle #(
  parameter int LIMIT_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dtb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dtb_pkg::CFG_DATA_W-1:0]  cfg_data,
  dtb_chan_if.sink                        req,
  dtb_chan_if.source                      resp
);
  import dtb_pkg::*;

  dtb_cmd_t    cmd;
  dtb_status_t sts;
  logic        ready;
  logic        resp_valid;
  out_item_t   resp_item;

  assign req.ready    = ready;
  assign resp.valid   = resp_valid;
  assign resp.payload = resp_item;

  dtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtb_datapath #(
    .LIMIT_BITS (LIMIT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (req.payload),
    .cmd        (cmd),
    .sts        (sts),
    .resp_valid (resp_valid),
    .resp_ready (resp.ready),
    .resp_item  (resp_item)
  );

  `ASSERT_CLK(a_one_word_at_a_time, clk, rst, (req.valid && ready) |=> !ready)
  `ASSERT_CLK(a_divide_follows_start, clk, rst, cmd.div_start |=> cmd.div_step)
  `ASSERT_CLK(a_commit_shows_result, clk, rst, cmd.commit |=> resp_valid)
  `ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.commit && resp_valid && !resp.ready)

endmodule
